>>> hdl/etl_pkg.sv
// Shared types, constants and helper functions of the expression token lexer.
package etl_pkg;

   // Widths of the number accumulator and of the line and column counters.
   localparam int VALUE_WIDTH       = 32;
   localparam int POS_WIDTH         = 16;

   // Token queue between the classifier and the token sequencer.
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {VALUE_WIDTH{1'b1}};
   localparam logic [POS_WIDTH-1:0]   POS_MAX   = {POS_WIDTH{1'b1}};

   // Token kinds.
   localparam logic [2:0] TOKEN_ERROR     = 3'd0;
   localparam logic [2:0] TOKEN_NUMBER    = 3'd1;
   localparam logic [2:0] TOKEN_OPERATOR  = 3'd2;
   localparam logic [2:0] TOKEN_SEMICOLON = 3'd3;
   localparam logic [2:0] TOKEN_START     = 3'd4;
   localparam logic [2:0] TOKEN_END       = 3'd5;
   localparam logic [2:0] TOKEN_EOF       = 3'd6;

   // Operator codes.
   localparam logic [1:0] OP_ADD      = 2'd0;
   localparam logic [1:0] OP_SUBTRACT = 2'd1;
   localparam logic [1:0] OP_MULTIPLY = 2'd2;
   localparam logic [1:0] OP_DIVIDE   = 2'd3;

   // Input item kinds.
   localparam logic ITEM_TEXT = 1'b0;
   localparam logic ITEM_EOT  = 1'b1;

   // Run modes of the classifier.
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_WORD   = 2'd1;
   localparam logic [1:0] MODE_NUMBER = 2'd2;

   // Characters with a meaning of their own.
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_PLUS      = 8'h2B;
   localparam logic [7:0] CHAR_MINUS     = 8'h2D;
   localparam logic [7:0] CHAR_STAR      = 8'h2A;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;

   localparam logic [2:0] WORD_LENGTH_MAX = 3'd7;
   localparam logic [2:0] START_LENGTH    = 3'd5;
   localparam logic [2:0] END_LENGTH      = 3'd3;

   // One accepted item's tokens: an optional finished run, then an optional
   // token of the item itself. Both share the line.
   typedef struct packed {
      logic                   flush_valid;
      logic [2:0]             flush_kind;
      logic [VALUE_WIDTH-1:0] flush_value;
      logic                   flush_overflow;
      logic [POS_WIDTH-1:0]   flush_column;
      logic                   cur_valid;
      logic [2:0]             cur_kind;
      logic [1:0]             cur_op;
      logic [POS_WIDTH-1:0]   cur_column;
      logic [POS_WIDTH-1:0]   line;
   } etl_record_type;

   typedef struct packed {
      logic full;
      logic empty;
   } etl_queue_status_type;

   // Letters of the keyword "start" by position.
   function automatic logic [7:0] start_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h73;
         3'd1:    ch = 8'h74;
         3'd2:    ch = 8'h61;
         3'd3:    ch = 8'h72;
         3'd4:    ch = 8'h74;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Letters of the keyword "end" by position.
   function automatic logic [7:0] end_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h65;
         3'd1:    ch = 8'h6E;
         3'd2:    ch = 8'h64;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Saturating position increment.
   function automatic logic [POS_WIDTH-1:0] pos_inc(input logic [POS_WIDTH-1:0] p);
      return (p == POS_MAX) ? p : p + POS_WIDTH'(1);
   endfunction

endpackage

>>> hdl/expression_token_lexer_unit.sv
// Top level of the expression token lexer: classifier, token queue and sequencer.
//
// Usage: the req channel takes one item per transfer, either a text byte
// (req_kind 0, byte on req_char_byte) or an end-of-text marker (req_kind 1).
// The rsp channel delivers one token per transfer with its kind, operator
// code, number value and overflow flag, line, start column, and a flag that
// marks the last token released by its input item. An item releases zero,
// one or two tokens; letter and digit runs are held until a later item ends them.
// A token released by an item is written into the queue when the item is accepted
// and reaches rsp_valid through the output register of the sequencer.
// Throughput: one item and one token per cycle while neither stall is raised. The
// classifier finishes an item in its accept cycle and writes a record of up to
// two tokens into a four-entry queue; the sequencer reads one token per cycle.
// An item that releases two tokens stays queued until both are sent, which
// the queue absorbs, since on average text releases at most one token per byte.
// When rsp_stall holds the output register, the queue fills and req_stall
// rises once it is full. Reset (synchronous) empties the queue and the
// output register, clears any held run and sets line 1, column 0.
module expression_token_lexer_unit
   import etl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_char_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_token_kind,
   output logic [1:0]  rsp_operator_code,
   output logic [31:0] rsp_number_value,
   output logic        rsp_value_overflow,
   output logic [15:0] rsp_token_line,
   output logic [15:0] rsp_token_column,
   output logic        rsp_last_token
);

   // Records flow from the classifier into the queue; the sequencer pops them.
   etl_queue_status_type queue_status;
   etl_record_type       push_record;
   etl_record_type       head_record;
   logic                 push;
   logic                 pop;

   etl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_char_byte (req_char_byte),
      .queue_status  (queue_status),
      .push          (push),
      .push_record   (push_record)
   );

   etl_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_record  (push_record),
      .pop          (pop),
      .head_record  (head_record),
      .queue_status (queue_status)
   );

   etl_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_record        (head_record),
      .queue_status       (queue_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_token_kind     (rsp_token_kind),
      .rsp_operator_code  (rsp_operator_code),
      .rsp_number_value   (rsp_number_value),
      .rsp_value_overflow (rsp_value_overflow),
      .rsp_token_line     (rsp_token_line),
      .rsp_token_column   (rsp_token_column),
      .rsp_last_token     (rsp_last_token)
   );

endmodule

>>> hdl/etl_front.sv
// Classifier: accepts text items, tracks runs and positions, builds token records.
module etl_front
   import etl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   input  logic [7:0]           req_char_byte,
   input  etl_queue_status_type queue_status,
   output logic                 push,
   output etl_record_type       push_record
);

   logic [1:0]             mode_ff, mode_in;
   logic [2:0]             length_ff, length_in;
   logic                   start_match_ff, start_match_in;
   logic                   end_match_ff, end_match_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   overflow_ff, overflow_in;
   logic [POS_WIDTH-1:0]   line_ff, line_in;
   logic [POS_WIDTH-1:0]   column_ff, column_in;
   logic [POS_WIDTH-1:0]   run_column_ff, run_column_in;

   logic                   accept;
   logic                   is_alpha;
   logic                   is_digit;
   logic                   ends_run;
   logic [2:0]             base_length;
   logic                   base_start;
   logic                   base_end;
   logic [VALUE_WIDTH-1:0] base_value;
   logic                   base_overflow;
   logic [VALUE_WIDTH+3:0] product;
   logic [2:0]             run_kind;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !queue_status.full;

   assign is_alpha = (req_kind == ITEM_TEXT) &&
                     (req_char_byte inside {[8'h61:8'h7A], [8'h41:8'h5A]});
   assign is_digit = (req_kind == ITEM_TEXT) && (req_char_byte inside {[8'h30:8'h39]});

   // A held run ends on anything that does not continue it.
   assign ends_run = !((is_alpha && mode_ff == MODE_WORD) ||
                       (is_digit && mode_ff == MODE_NUMBER));

   always_comb begin
      if (mode_ff == MODE_WORD) begin
         if (start_match_ff && length_ff == START_LENGTH) begin
            run_kind = TOKEN_START;
         end else if (end_match_ff && length_ff == END_LENGTH) begin
            run_kind = TOKEN_END;
         end else begin
            run_kind = TOKEN_ERROR;
         end
      end else begin
         run_kind = TOKEN_NUMBER;
      end
   end

   // Starting values of the run that this item continues or opens.
   assign base_length   = (mode_ff == MODE_WORD) ? length_ff : 3'd0;
   assign base_start    = (mode_ff == MODE_WORD) ? start_match_ff : 1'b1;
   assign base_end      = (mode_ff == MODE_WORD) ? end_match_ff : 1'b1;
   assign base_value    = (mode_ff == MODE_NUMBER) ? value_ff : '0;
   assign base_overflow = (mode_ff == MODE_NUMBER) ? overflow_ff : 1'b0;

   // Ten times the value plus the digit, with room to see an overflow.
   assign product = ({4'b0000, base_value} << 3) + ({4'b0000, base_value} << 1) +
                    {{VALUE_WIDTH{1'b0}}, req_char_byte[3:0]};

   always_comb begin
      push_record                = '0;
      push_record.line           = line_ff;
      push_record.flush_valid    = ends_run && (mode_ff != MODE_IDLE);
      push_record.flush_kind     = run_kind;
      push_record.flush_value    = (mode_ff == MODE_NUMBER) ? value_ff : '0;
      push_record.flush_overflow = (mode_ff == MODE_NUMBER) && overflow_ff;
      push_record.flush_column   = run_column_ff;
      push_record.cur_column     = column_ff;
      push_record.cur_kind       = TOKEN_ERROR;
      push_record.cur_op         = OP_ADD;
      push_record.cur_valid      = 1'b0;
      if (req_kind == ITEM_EOT) begin
         push_record.cur_valid = 1'b1;
         push_record.cur_kind  = TOKEN_EOF;
      end else if (!is_alpha && !is_digit) begin
         push_record.cur_valid = 1'b1;
         case (req_char_byte)
            CHAR_NEWLINE, CHAR_SPACE, CHAR_TAB, CHAR_CR: begin
               push_record.cur_valid = 1'b0;
            end
            CHAR_PLUS: begin
               push_record.cur_kind = TOKEN_OPERATOR;
               push_record.cur_op   = OP_ADD;
            end
            CHAR_MINUS: begin
               push_record.cur_kind = TOKEN_OPERATOR;
               push_record.cur_op   = OP_SUBTRACT;
            end
            CHAR_STAR: begin
               push_record.cur_kind = TOKEN_OPERATOR;
               push_record.cur_op   = OP_MULTIPLY;
            end
            CHAR_SLASH: begin
               push_record.cur_kind = TOKEN_OPERATOR;
               push_record.cur_op   = OP_DIVIDE;
            end
            CHAR_SEMICOLON: begin
               push_record.cur_kind = TOKEN_SEMICOLON;
            end
            default: begin
               push_record.cur_kind = TOKEN_ERROR;
            end
         endcase
      end
   end

   assign push = accept && (push_record.flush_valid || push_record.cur_valid);

   always_comb begin
      mode_in        = mode_ff;
      length_in      = length_ff;
      start_match_in = start_match_ff;
      end_match_in   = end_match_ff;
      value_in       = value_ff;
      overflow_in    = overflow_ff;
      line_in        = line_ff;
      column_in      = column_ff;
      run_column_in  = run_column_ff;
      if (accept) begin
         if (is_alpha) begin
            mode_in        = MODE_WORD;
            if (mode_ff != MODE_WORD) begin
               run_column_in = column_ff;
            end
            start_match_in = base_start && (base_length < START_LENGTH) &&
                             (start_char(base_length) == req_char_byte);
            end_match_in   = base_end && (base_length < END_LENGTH) &&
                             (end_char(base_length) == req_char_byte);
            length_in      = (base_length == WORD_LENGTH_MAX) ? base_length :
                             base_length + 3'd1;
            column_in      = pos_inc(column_ff);
         end else if (is_digit) begin
            mode_in = MODE_NUMBER;
            if (mode_ff != MODE_NUMBER) begin
               run_column_in = column_ff;
            end
            if (base_overflow || product[VALUE_WIDTH+3:VALUE_WIDTH] != 4'd0) begin
               value_in    = VALUE_MAX;
               overflow_in = 1'b1;
            end else begin
               value_in    = product[VALUE_WIDTH-1:0];
               overflow_in = 1'b0;
            end
            column_in = pos_inc(column_ff);
         end else begin
            mode_in = MODE_IDLE;
            if (req_kind == ITEM_TEXT) begin
               if (req_char_byte == CHAR_NEWLINE) begin
                  line_in   = pos_inc(line_ff);
                  column_in = '0;
               end else begin
                  column_in = pos_inc(column_ff);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         length_ff      <= 3'd0;
         start_match_ff <= 1'b1;
         end_match_ff   <= 1'b1;
         value_ff       <= '0;
         overflow_ff    <= 1'b0;
         line_ff        <= POS_WIDTH'(1);
         column_ff      <= '0;
         run_column_ff  <= '0;
      end else begin
         mode_ff        <= mode_in;
         length_ff      <= length_in;
         start_match_ff <= start_match_in;
         end_match_ff   <= end_match_in;
         value_ff       <= value_in;
         overflow_ff    <= overflow_in;
         line_ff        <= line_in;
         column_ff      <= column_in;
         run_column_ff  <= run_column_in;
      end
   end

endmodule

>>> hdl/etl_queue.sv
// Short first-in first-out queue of token records.
module etl_queue
   import etl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  etl_record_type       push_record,
   input  logic                 pop,
   output etl_record_type       head_record,
   output etl_queue_status_type queue_status
);

   etl_record_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;

   assign head_record        = entries_ff[rd_ptr_ff];
   assign queue_status.full  = (count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_COUNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_record;
      end
   end

endmodule

>>> hdl/etl_back.sv
// Token sequencer: splits records into single tokens and holds the result register.
module etl_back
   import etl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  etl_record_type       head_record,
   input  etl_queue_status_type queue_status,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_token_kind,
   output logic [1:0]           rsp_operator_code,
   output logic [31:0]          rsp_number_value,
   output logic                 rsp_value_overflow,
   output logic [15:0]          rsp_token_line,
   output logic [15:0]          rsp_token_column,
   output logic                 rsp_last_token
);

   logic                   valid_ff, valid_in;
   logic                   second_ff, second_in;
   logic [2:0]             kind_ff, kind_in;
   logic [1:0]             op_ff, op_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   overflow_ff, overflow_in;
   logic [POS_WIDTH-1:0]   line_ff, line_in;
   logic [POS_WIDTH-1:0]   column_ff, column_in;
   logic                   last_ff, last_in;

   logic                   load;
   logic                   take;
   logic                   send_flush;

   assign load       = !valid_ff || !rsp_stall;
   assign take       = load && !queue_status.empty;
   assign send_flush = !second_ff && head_record.flush_valid;
   assign pop        = take && !(send_flush && head_record.cur_valid);

   always_comb begin
      valid_in    = valid_ff;
      second_in   = second_ff;
      kind_in     = kind_ff;
      op_in       = op_ff;
      value_in    = value_ff;
      overflow_in = overflow_ff;
      line_in     = line_ff;
      column_in   = column_ff;
      last_in     = last_ff;
      if (load) begin
         valid_in = take;
      end
      if (take) begin
         line_in   = head_record.line;
         second_in = send_flush && head_record.cur_valid;
         if (send_flush) begin
            kind_in     = head_record.flush_kind;
            op_in       = OP_ADD;
            value_in    = head_record.flush_value;
            overflow_in = head_record.flush_overflow;
            column_in   = head_record.flush_column;
            last_in     = !head_record.cur_valid;
         end else begin
            kind_in     = head_record.cur_kind;
            op_in       = head_record.cur_op;
            value_in    = '0;
            overflow_in = 1'b0;
            column_in   = head_record.cur_column;
            last_in     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      op_ff       <= op_in;
      value_ff    <= value_in;
      overflow_ff <= overflow_in;
      line_ff     <= line_in;
      column_ff   <= column_in;
      last_ff     <= last_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_token_kind     = kind_ff;
   assign rsp_operator_code  = op_ff;
   assign rsp_number_value   = value_ff;
   assign rsp_value_overflow = overflow_ff;
   assign rsp_token_line     = line_ff;
   assign rsp_token_column   = column_ff;
   assign rsp_last_token     = last_ff;

endmodule
